[rtl/dwc_pkg.sv]
`default_nettype none
package dwc_pkg;
  localparam int CharW  = 8;
  localparam int TotalW = 9;
  localparam logic [TotalW-1:0] TotalSat = 9'd511;

  // Word handed along the row of cells during a search.
  typedef struct packed {
    logic       valid;
    logic       found;
  } probe_t;

  function automatic logic is_letter(input logic [CharW-1:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction
endpackage
`default_nettype wire

[rtl/dwc_cell.sv]
`default_nettype none
module dwc_cell #(
  parameter int WordBits = 128,
  parameter int LenW     = 5
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              clear,
  input  wire                              load,
  input  wire [WordBits-1:0]               load_word,
  input  wire [LenW-1:0]                   load_len,
  input  wire                              prev_used,
  input  wire                              prev_load,
  input  wire [WordBits-1:0]               probe_word,
  input  wire [LenW-1:0]                   probe_len,
  input  wire dwc_pkg::probe_t             probe_in,
  output dwc_pkg::probe_t                  probe_out,
  output logic                             used,
  output logic                             take
);
  import dwc_pkg::*;

  logic [WordBits-1:0] word;
  logic [LenW-1:0]     len;

  // The first empty cell behind a used one takes the new word.
  assign take = load && prev_used && !used && prev_load;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      used <= 1'b0;
    end else if (take) begin
      used <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      word <= load_word;
      len  <= load_len;
    end
  end

  // Compare the probe as it passes this cell and hand it on.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      probe_out <= '0;
    end else begin
      probe_out.valid <= probe_in.valid;
      probe_out.found <= probe_in.found ||
                         (probe_in.valid && used && len == probe_len &&
                          word == probe_word);
    end
  end
endmodule
`default_nettype wire

[rtl/distinct_word_counter.sv]
`default_nettype none
// Distinct word counter. One byte per start; busy stays high while an item is
// worked on and a result appears on the result ports for one cycle with strobe
// high; the receiver cannot stall it. A letter or a separator with no open word
// takes the report step directly. A closing separator sends the word down a row
// of MAX_WORDS compare cells, one cell per cycle, and then reports. Words
// compare case-sensitively on their first MAX_WORD_LEN letters.
module distinct_word_counter #(
  parameter int MAX_WORDS    = 256,
  parameter int MAX_WORD_LEN = 16
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         start,
  output logic                        busy,
  input  wire [7:0]                   char_code,
  input  wire                         end_of_text,
  output logic                        strobe,
  output logic [8:0]                  distinct_total,
  output logic                        new_word_added,
  output logic                        table_full,
  output logic                        word_truncated,
  output logic                        final_count
);
  import dwc_pkg::*;

  localparam int WordBits = MAX_WORD_LEN * CharW;
  localparam int LenW     = $clog2(MAX_WORD_LEN + 1);
  localparam int CntW     = $clog2(MAX_WORDS + 1);
  localparam int StepW    = $clog2(MAX_WORDS + 2);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]          state;
  logic [WordBits-1:0] pword;
  logic [LenW-1:0]     plen;
  logic                povf;
  logic [CntW-1:0]     stored;
  logic [StepW-1:0]    step;
  logic                eot;
  logic                closing;
  logic                found;
  logic                load;
  logic                clear;

  probe_t              chain [MAX_WORDS+1];
  logic [MAX_WORDS:0]  used_v;
  logic [MAX_WORDS:0]  prev_load_v;
  logic [MAX_WORDS-1:0] take_v;

  assign busy = (state != S_IDLE);
  assign used_v[0] = 1'b1;
  assign prev_load_v[0] = 1'b1;
  assign chain[0] = {(state == S_RUN) && (step == '0), 1'b0};

  // Row of compare cells; each also holds one stored word.
  for (genvar i = 0; i < MAX_WORDS; i++) begin : g_cell
    dwc_cell #(.WordBits(WordBits), .LenW(LenW)) u_cell (
      .clk(clk), .rst(rst), .clear(clear), .load(load),
      .load_word(pword), .load_len(plen),
      .prev_used(used_v[i]), .prev_load(prev_load_v[i]),
      .probe_word(pword), .probe_len(plen),
      .probe_in(chain[i]), .probe_out(chain[i+1]),
      .used(used_v[i+1]), .take(take_v[i])
    );
    assign prev_load_v[i+1] = prev_load_v[i] && !take_v[i];
  end

  assign found = chain[MAX_WORDS].found;
  assign load  = (state == S_RUN) && (step == StepW'(MAX_WORDS)) && !found &&
                 (stored < CntW'(MAX_WORDS));
  assign clear = (state == S_DONE) && eot;

  // Sequencer: accept, search, report.
  // Letters past the open word are kept at zero so whole-word compares hold.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pword <= '0;
      plen  <= '0;
      povf  <= 1'b0;
      stored <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            eot <= end_of_text;
            if (!end_of_text && is_letter(char_code)) begin
              if (plen < LenW'(MAX_WORD_LEN)) begin
                pword[plen*CharW +: CharW] <= char_code;
                plen <= plen + 1'b1;
              end else begin
                povf <= 1'b1;
              end
              closing <= 1'b0;
              state <= S_DONE;
              new_word_added <= 1'b0;
              table_full <= 1'b0;
              word_truncated <= 1'b0;
            end else if (plen == '0) begin
              closing <= 1'b0;
              state <= S_DONE;
              new_word_added <= 1'b0;
              table_full <= 1'b0;
              word_truncated <= 1'b0;
            end else begin
              closing <= 1'b1;
              step <= '0;
              state <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (step == StepW'(MAX_WORDS)) begin
            new_word_added <= load;
            table_full <= !found && !load;
            word_truncated <= povf;
            if (load) stored <= stored + 1'b1;
            state <= S_DONE;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_DONE: begin
          if (closing || eot) begin
            pword <= '0;
            plen <= '0;
            povf <= 1'b0;
          end
          if (eot) stored <= '0;
          distinct_total <= (CntW > TotalW && stored > CntW'(TotalSat)) ? TotalSat
                            : TotalW'(stored);
          final_count <= eot;
          strobe <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[tb/dwc_checker.sv]
`timescale 1ns / 1ps
module dwc_checker #(
  parameter int MAX_WORDS    = 256,
  parameter int MAX_WORD_LEN = 16
) (
  input  wire       clk,
  input  wire       rst,
  input  wire       start,
  input  wire       busy,
  input  wire [7:0] char_code,
  input  wire       end_of_text,
  input  wire       strobe,
  input  wire [8:0] distinct_total,
  input  wire       new_word_added,
  input  wire       table_full,
  input  wire       word_truncated,
  input  wire       final_count,
  output int        fail_count,
  output int        pending_results
);
  typedef struct packed {
    logic [8:0] total;
    logic       added;
    logic       full;
    logic       trunc;
    logic       fin;
  } word_result_t;

  word_result_t expected_results[$];

  // Shadow copy of the word table and the open word.
  logic [7:0] open_word [MAX_WORD_LEN];
  int         open_len;
  bit         open_over;
  logic [7:0] known_words [MAX_WORDS][MAX_WORD_LEN];
  int         known_len [MAX_WORDS];
  int         known_count;

  function automatic bit letter_code(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit open_word_known();
    bit same;
    for (int w = 0; w < known_count; w++) begin
      if (known_len[w] == open_len) begin
        same = 1'b1;
        for (int i = 0; i < open_len; i++)
          if (known_words[w][i] != open_word[i]) same = 1'b0;
        if (same) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Works out the result of one transfer and updates the shadow state.
  function automatic word_result_t count_words(input logic [7:0] c, input bit eot);
    word_result_t r;
    r = '0;
    if (!eot && letter_code(c)) begin
      if (open_len < MAX_WORD_LEN) begin
        open_word[open_len] = c;
        open_len++;
      end else begin
        open_over = 1'b1;
      end
    end else begin
      if (open_len > 0) begin
        r.trunc = open_over;
        if (!open_word_known()) begin
          if (known_count < MAX_WORDS) begin
            for (int i = 0; i < open_len; i++) known_words[known_count][i] = open_word[i];
            known_len[known_count] = open_len;
            known_count++;
            r.added = 1'b1;
          end else begin
            r.full = 1'b1;
          end
        end
      end
      open_len  = 0;
      open_over = 1'b0;
    end
    r.total = (known_count > 511) ? 9'd511 : 9'(known_count);
    r.fin   = eot;
    if (eot) known_count = 0;
    return r;
  endfunction

  assign pending_results = expected_results.size();

  // Predict on each accepted input transfer and compare each result.
  always @(posedge clk) begin
    word_result_t want;
    int errs;
    errs = 0;
    if (rst) begin
      open_len    <= 0;
      open_over   <= 1'b0;
      known_count <= 0;
      fail_count  <= 0;
      expected_results.delete();
    end else begin
      if (strobe) begin
        if (expected_results.size() == 0) begin
          $error("result with no transfer waiting: total %0d", distinct_total);
          errs++;
        end else begin
          want = expected_results.pop_front();
          if (distinct_total !== want.total) begin
            $error("distinct_total: expected %0d, actual %0d", want.total, distinct_total);
            errs++;
          end
          if (new_word_added !== want.added) begin
            $error("new_word_added: expected %0d, actual %0d", want.added, new_word_added);
            errs++;
          end
          if (table_full !== want.full) begin
            $error("table_full: expected %0d, actual %0d", want.full, table_full);
            errs++;
          end
          if (word_truncated !== want.trunc) begin
            $error("word_truncated: expected %0d, actual %0d", want.trunc, word_truncated);
            errs++;
          end
          if (final_count !== want.fin) begin
            $error("final_count: expected %0d, actual %0d", want.fin, final_count);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
      if (start && !busy) expected_results.push_back(count_words(char_code, end_of_text));
    end
  end
endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  localparam int MAX_WORDS    = 256;
  localparam int MAX_WORD_LEN = 16;
  localparam int IdleLimit    = 20000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [7:0] char_code = 8'h00;
  logic       end_of_text = 1'b0;
  wire        busy, strobe, new_word_added, table_full, word_truncated, final_count;
  wire  [8:0] distinct_total;
  int         fail_count, pending_results;
  int         idle_cycles = 0;

  always #5 clk = ~clk;

  distinct_word_counter #(.MAX_WORDS(MAX_WORDS), .MAX_WORD_LEN(MAX_WORD_LEN)) u_dut (
    .clk, .rst, .start, .busy, .char_code, .end_of_text, .strobe, .distinct_total,
    .new_word_added, .table_full, .word_truncated, .final_count
  );

  dwc_checker #(.MAX_WORDS(MAX_WORDS), .MAX_WORD_LEN(MAX_WORD_LEN)) u_checker (
    .clk, .rst, .start, .busy, .char_code, .end_of_text, .strobe, .distinct_total,
    .new_word_added, .table_full, .word_truncated, .final_count, .fail_count,
    .pending_results
  );

  // Watchdog: counts cycles in which no transfer of either kind happens.
  always @(posedge clk) begin
    if (rst || strobe || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  int gap_left = 0;
  int burst_left = 0;
  int sent = 0;

  // Sends one byte and holds it until the transfer. Gaps fall between bursts,
  // and start stays high within a burst so the next byte follows at once.
  task automatic send_byte(input logic [7:0] c, input bit eot);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
    end
    if (gap_left > 0) begin
      start <= 1'b0;
      repeat (gap_left) @(posedge clk);
      gap_left = 0;
    end
    burst_left--;
    sent++;
    start       <= 1'b1;
    char_code   <= c;
    end_of_text <= eot;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(0, 1) != 0) ? 8'($urandom_range(65, 90)) : 8'($urandom_range(97, 122));
  endfunction

  function automatic logic [7:0] rand_separator();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z"));
    return c;
  endfunction

  int word_len;
  logic [7:0] vocab [8][4];

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: letter edges, repeat, case, zero byte, long word, separators.
    send_byte("A", 0); send_byte("z", 0); send_byte(8'h00, 0);
    send_byte("A", 0); send_byte("z", 0); send_byte(" ", 0);
    send_byte("a", 0); send_byte("Z", 0); send_byte(8'hFF, 0);
    send_byte(8'h40, 0); send_byte(8'h5B, 0); send_byte(8'h60, 0); send_byte(8'h7B, 0);
    repeat (18) send_byte("Q", 0);
    send_byte(8'h7F, 1);
    send_byte(8'h55, 1);
    send_byte("x", 0); send_byte("x", 1);

    // Fill the table past MAX_WORDS with distinct two-letter words.
    for (int i = 0; i < MAX_WORDS + 3; i++) begin
      send_byte(8'("A" + i / 26), 0);
      send_byte(8'("a" + i % 26), 0);
      send_byte(".", 0);
    end
    send_byte("A", 0); send_byte("a", 0); send_byte(8'h80, 1);

    // Random texts from a small vocabulary so repeats are common.
    for (int v = 0; v < 8; v++)
      for (int i = 0; i < 4; i++) vocab[v][i] = rand_letter();
    while (sent < 1169) begin
      case ($urandom_range(0, 9))
        0: begin
          send_byte(8'($urandom_range(0, 255)), 1);
        end
        1, 2: begin
          word_len = $urandom_range(1, 20);
          repeat (word_len) send_byte(rand_letter(), 0);
        end
        3: begin
          send_byte(8'($urandom_range(0, 255)), 0);
        end
        default: begin
          word_len = $urandom_range(1, 4);
          for (int i = 0; i < word_len; i++) send_byte(vocab[$urandom_range(0, 7)][i], 0);
        end
      endcase
      send_byte(rand_separator(), 0);
    end
    send_byte(8'h00, 1);
    start <= 1'b0;

    while (pending_results != 0) @(posedge clk);
    repeat (MAX_WORDS + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
